// ----- rtl/imrot_pkg.sv -----
package imrot_pkg;

	// Frame store geometry.
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int CW          = $clog2(MAX_WIDTH);
	localparam int RW          = $clog2(MAX_HEIGHT);
	localparam int BANK_DEPTH  = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int PIX_W       = 8;
	localparam int FRAC        = 14;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COS    = 2'd2;
	localparam logic [1:0] REG_SIN    = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [8:0]         WIDTH_RESET  = 9'd256;
	localparam logic [8:0]         HEIGHT_RESET = 9'd256;
	localparam logic signed [15:0] COS_RESET    = 16'sd16057;
	localparam logic signed [15:0] SIN_RESET    = 16'sd3255;

	// Input mode codes.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic             we;
		logic [CW-1:0]    col;
		logic [RW-1:0]    row;
		logic [PIX_W-1:0] pixel;
	} store_wr_t;

	typedef struct packed {
		logic          re;
		logic [CW-1:0] ix;
		logic [RW-1:0] iy;
	} store_rd_t;

	// The four neighbors of a source point: a at the lower index, b at the
	// next one; first letter is x, second is y.
	typedef struct packed {
		logic [PIX_W-1:0] aa;
		logic [PIX_W-1:0] ba;
		logic [PIX_W-1:0] ab;
		logic [PIX_W-1:0] bb;
	} quad_t;

endpackage

// ----- rtl/imrot_ram.sv -----
module imrot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/imrot_store.sv -----
module imrot_store (
	input  logic                  clk,
	input  imrot_pkg::store_wr_t  wr,
	input  imrot_pkg::store_rd_t  rd,
	output imrot_pkg::quad_t      quad
);
	import imrot_pkg::*;

	localparam int BANK_AW = $clog2(BANK_DEPTH);

	// Bank {y parity, x parity}; inside a bank the address is the halved
	// row and column. The pair ix, ix+1 always covers one even and one
	// odd column, so all four neighbors come from distinct banks.
	logic [CW-2:0]      xo, xe;
	logic [RW-2:0]      yo, ye;
	logic [BANK_AW-1:0] waddr;
	logic [PIX_W-1:0]   bank_q [4];
	logic [1:0]         par_q;

	assign xo    = rd.ix[CW-1:1];
	assign xe    = rd.ix[CW-1:1] + (CW-1)'(rd.ix[0]);
	assign yo    = rd.iy[RW-1:1];
	assign ye    = rd.iy[RW-1:1] + (RW-1)'(rd.iy[0]);
	assign waddr = {wr.row[RW-1:1], wr.col[CW-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);
		logic               bank_we;
		logic [BANK_AW-1:0] bank_raddr;

		assign bank_we    = wr.we && ({wr.row[0], wr.col[0]} == BID);
		assign bank_raddr = {(BID[1] ? yo : ye), (BID[0] ? xo : xe)};

		imrot_ram #(
			.WIDTH(PIX_W),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (bank_we),
			.waddr(waddr),
			.wdata(wr.pixel),
			.re   (rd.re),
			.raddr(bank_raddr),
			.rdata(bank_q[b])
		);
	end

	always_ff @(posedge clk) begin
		if (rd.re) begin
			par_q <= {rd.iy[0], rd.ix[0]};
		end
	end

	// Route the banks back to neighbor positions by the parity of (ix,iy).
	always_comb begin
		case (par_q)
			2'b01: begin
				quad = {bank_q[1], bank_q[0], bank_q[3], bank_q[2]};
			end
			2'b10: begin
				quad = {bank_q[2], bank_q[3], bank_q[0], bank_q[1]};
			end
			2'b11: begin
				quad = {bank_q[3], bank_q[2], bank_q[1], bank_q[0]};
			end
			default: begin
				quad = {bank_q[0], bank_q[1], bank_q[2], bank_q[3]};
			end
		endcase
	end

endmodule

// ----- rtl/image_rotate_bilinear.sv -----
// Bilinear rotation of one 8-bit image channel.
// Input beats on the s_ channel carry tuser = mode and tdata = {pixel, row, col}.
// A load beat (mode 0) writes pixel into the frame store at (col,row) and
// produces no output beat. A sample beat (mode 1) produces exactly one output
// beat on the m_ channel: tdata = sample_value, tuser = in_bounds.
// The source point is cos*col - sin*row, sin*col + cos*row in Q.14; the four
// neighbors are blended and truncated, and a point outside the image gives 0.
// The pipeline has six register stages. One beat per cycle is accepted in
// steady state while the receiver does not stall: the frame store is split
// into four banks by row and column parity, so a single read returns all
// four neighbors. Loads write and samples read in the same stage, so a
// sample sees every load accepted before it.
// When the receiver stalls, the pipeline keeps accepting beats until its
// empty stages are full; s_tready then follows m_tready.
// Reset clears the pipeline and restores the registers to 256 x 256 with
// the default angle; the store content is undefined until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are expected only while the pipeline is empty.
module image_rotate_bilinear (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // col [7:0], row [15:8], pixel [23:16]
	input  logic [0:0]  s_tuser,   // mode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // sample_value [7:0]
	output logic [0:0]  m_tuser,   // in_bounds [0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import imrot_pkg::*;

	// Configuration registers.
	logic [8:0]         image_width_q, image_height_q;
	logic signed [15:0] cos_q, sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			cos_q          <= COS_RESET;
			sin_q          <= SIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  image_width_q  <= cfg_data[8:0];
				REG_HEIGHT: image_height_q <= cfg_data[8:0];
				REG_COS:    cos_q          <= $signed(cfg_data);
				REG_SIN:    sin_q          <= $signed(cfg_data);
				default:    ;
			endcase
		end
	end

	// Stage valids and per-stage advance. A stage takes a new beat when it
	// is empty or its contents move on, so bubbles are squeezed out while
	// the output is stalled.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || m_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	// Stage payloads.
	logic               mode_s1, mode_s2, mode_s3;
	logic [CW-1:0]      col_s1, col_s2, col_s3;
	logic [RW-1:0]      row_s1, row_s2, row_s3;
	logic [PIX_W-1:0]   pixel_s1, pixel_s2, pixel_s3;
	logic signed [24:0] pcc_s1, psr_s1, psc_s1, pcr_s1;
	logic signed [25:0] sx_s2, sy_s2;
	logic               inb_s3, inb_s4, inb_s5;
	logic [CW-1:0]      ix_s3;
	logic [RW-1:0]      iy_s3;
	logic [FRAC-1:0]    fx_s3, fy_s3, fx_s4, fy_s4, fy_s5;
	logic [21:0]        top_s5, bot_s5;
	logic [PIX_W-1:0]   value_s6;
	logic               inb_s6;

	// Stage 1: the four coordinate products, one multiplier each.
	logic signed [8:0] col_x, row_x;
	assign col_x = $signed({1'b0, s_tdata[7:0]});
	assign row_x = $signed({1'b0, s_tdata[15:8]});

	// Stage 2 to 3: bounds check against the saturated image size.
	logic [8:0]  w_eff, h_eff, wm1, hm1;
	logic [24:0] lim_x, lim_y;
	logic        xin, yin, inb_c;

	always_comb begin
		w_eff = (image_width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : image_width_q;
		h_eff = (image_height_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : image_height_q;
		wm1   = w_eff - 9'd1;
		hm1   = h_eff - 9'd1;
		lim_x = 25'({wm1[CW-1:0], {FRAC{1'b0}}});
		lim_y = 25'({hm1[RW-1:0], {FRAC{1'b0}}});
		xin   = !sx_s2[25] && (sx_s2[24:0] <= lim_x);
		yin   = !sy_s2[25] && (sy_s2[24:0] <= lim_y);
		inb_c = (w_eff != 9'd0) && (h_eff != 9'd0) && xin && yin;
	end

	// Stage 3: the frame store. Loads write here, samples read here, in the
	// same stage, which keeps the store in beat order.
	store_wr_t st_wr;
	store_rd_t st_rd;
	quad_t     quad;

	always_comb begin
		st_wr.we    = v_s3 && en4 && (mode_s3 == MODE_LOAD);
		st_wr.col   = col_s3;
		st_wr.row   = row_s3;
		st_wr.pixel = pixel_s3;
		st_rd.re    = v_s3 && en4 && (mode_s3 == MODE_SAMPLE) && inb_s3;
		st_rd.ix    = ix_s3;
		st_rd.iy    = iy_s3;
	end

	imrot_store u_store (
		.clk (clk),
		.wr  (st_wr),
		.rd  (st_rd),
		.quad(quad)
	);

	// Stage 4: horizontal blend, written as a + (b - a) * fx. A neighbor
	// with zero weight (the far column or row at an image edge) is replaced
	// by one that was read with weight, so nothing unwritten reaches the sum.
	logic               fx0, fy0;
	logic [PIX_W-1:0]   ba_m, ab_m, bb_m;
	logic signed [8:0]  dtop, dbot;
	logic signed [23:0] top_c, bot_c;

	always_comb begin
		fx0   = (fx_s4 == '0);
		fy0   = (fy_s4 == '0);
		ba_m  = fx0 ? quad.aa : quad.ba;
		ab_m  = fy0 ? quad.aa : quad.ab;
		bb_m  = fx0 ? ab_m : (fy0 ? quad.ba : quad.bb);
		dtop  = $signed({1'b0, ba_m}) - $signed({1'b0, quad.aa});
		dbot  = $signed({1'b0, bb_m}) - $signed({1'b0, ab_m});
		top_c = $signed({2'b00, quad.aa, {FRAC{1'b0}}})
			+ dtop * $signed({1'b0, fx_s4});
		bot_c = $signed({2'b00, ab_m, {FRAC{1'b0}}})
			+ dbot * $signed({1'b0, fx_s4});
	end

	// Stage 5: vertical blend, top + (bot - top) * fy, then truncation.
	logic signed [22:0] dv;
	logic signed [37:0] t_c;

	always_comb begin
		dv  = $signed({1'b0, bot_s5}) - $signed({1'b0, top_s5});
		t_c = $signed({2'b00, top_s5, {FRAC{1'b0}}}) + dv * $signed({1'b0, fy_s5});
	end

	// Valid bits; load beats leave the pipeline after the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3 && (mode_s3 == MODE_SAMPLE);
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1  <= s_tuser[0];
			col_s1   <= s_tdata[7:0];
			row_s1   <= s_tdata[15:8];
			pixel_s1 <= s_tdata[23:16];
			pcc_s1   <= cos_q * col_x;
			psr_s1   <= sin_q * row_x;
			psc_s1   <= sin_q * col_x;
			pcr_s1   <= cos_q * row_x;
		end
		if (en2) begin
			mode_s2  <= mode_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pixel_s2 <= pixel_s1;
			sx_s2    <= 26'(pcc_s1) - 26'(psr_s1);
			sy_s2    <= 26'(psc_s1) + 26'(pcr_s1);
		end
		if (en3) begin
			mode_s3  <= mode_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			pixel_s3 <= pixel_s2;
			inb_s3   <= inb_c;
			ix_s3    <= sx_s2[FRAC+CW-1:FRAC];
			iy_s3    <= sy_s2[FRAC+RW-1:FRAC];
			fx_s3    <= sx_s2[FRAC-1:0];
			fy_s3    <= sy_s2[FRAC-1:0];
		end
		if (en4) begin
			inb_s4 <= inb_s3;
			fx_s4  <= fx_s3;
			fy_s4  <= fy_s3;
		end
		if (en5) begin
			inb_s5 <= inb_s4;
			fy_s5  <= fy_s4;
			top_s5 <= top_c[21:0];
			bot_s5 <= bot_c[21:0];
		end
		if (en6) begin
			inb_s6   <= inb_s5;
			value_s6 <= inb_s5 ? t_c[2*FRAC+PIX_W-1:2*FRAC] : '0;
		end
	end

	assign m_tvalid   = v_s6;
	assign m_tdata    = value_s6;
	assign m_tuser[0] = inb_s6;

endmodule
